[design/wcp_pkg.sv]
// Shared types and constants of the WAV chunk parser.
package wcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  localparam logic ERR_LAYOUT = 1'b0;
  localparam logic ERR_EOF    = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] REG_STEREO_OUTPUT = 3'd0;

  // One parsed action: a sample (maybe duplicated to both channels) or an error.
  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               channel;
    logic               last;
    logic               error_code;
    logic               dup;
  } wcp_entry_t;

  typedef struct packed {
    logic       push;
    wcp_entry_t entry;
  } wcp_push_t;

endpackage

[design/wcp_if.sv]
// Valid/ready channel interfaces for file bytes and parser results.
interface wcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wcp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] sample;
  logic               channel;
  logic               last;
  logic               error_code;

  modport source (output valid, output kind, output sample, output channel, output last,
                  output error_code, input ready);
  modport sink (input valid, input kind, input sample, input channel, input last,
                input error_code, output ready);
endinterface

[design/wcp_front.sv]
// Byte parser: walks the RIFF chunks and turns each byte into at most one queue entry.
module wcp_front
  import wcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  input  logic       stereo_output,
  output wcp_push_t  push_out
);

  typedef enum logic [3:0] {
    PH_TAG, PH_RIFF_SIZE, PH_FMT_SIZE, PH_FMT_BODY,
    PH_SKIP_SIZE, PH_SKIP, PH_DATA_SIZE, PH_DATA
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  field_idx, field_idx_next;
  logic [31:0] word, word_next;
  logic [31:0] chunk_rem, chunk_rem_next;
  logic [15:0] channel_count, channel_count_next;
  logic [30:0] samples_rem, samples_rem_next;
  logic [7:0]  low_hold, low_hold_next;
  logic        dup_mode, dup_mode_next;
  logic        finished, finished_next;

  logic [1:0]  idx;
  logic        layout_err;
  logic        ok_pass, ok_dup;
  logic        ch;
  logic        is_last;
  wcp_entry_t  entry;
  logic        push;

  assign idx     = field_idx[1:0];
  assign ok_pass = (stereo_output && channel_count == 16'd2) ||
                   (!stereo_output && channel_count == 16'd1);
  assign ok_dup  = stereo_output && channel_count == 16'd1;
  assign ch      = field_idx[1];

  always_comb begin
    phase_next         = phase;
    field_idx_next     = field_idx;
    word_next          = word;
    chunk_rem_next     = chunk_rem;
    channel_count_next = channel_count;
    samples_rem_next   = samples_rem;
    low_hold_next      = low_hold;
    dup_mode_next      = dup_mode;
    finished_next      = finished;
    layout_err         = 1'b0;
    is_last            = 1'b0;
    push               = 1'b0;
    entry              = '0;

    if (!finished) begin
      unique case (phase)
        PH_TAG, PH_RIFF_SIZE, PH_FMT_SIZE, PH_SKIP_SIZE, PH_DATA_SIZE: begin
          word_next = ((idx == 2'd0) ? 32'd0 : word) |
                      ({24'd0, file_byte} << {idx, 3'b000});
          field_idx_next = {3'd0, idx} + 5'd1;
          if (idx == 2'd3) begin
            field_idx_next = 5'd0;
            unique case (phase)
              PH_TAG: begin
                if (word_next == TAG_RIFF)      phase_next = PH_RIFF_SIZE;
                else if (word_next == TAG_WAVE) phase_next = PH_TAG;
                else if (word_next == TAG_FMT)  phase_next = PH_FMT_SIZE;
                else if (word_next == TAG_DATA) phase_next = PH_DATA_SIZE;
                else                            phase_next = PH_SKIP_SIZE;
              end
              PH_RIFF_SIZE: phase_next = PH_TAG;
              PH_FMT_SIZE: begin
                chunk_rem_next = word_next;
                phase_next     = PH_FMT_BODY;
              end
              PH_SKIP_SIZE: begin
                chunk_rem_next = word_next;
                phase_next     = (word_next != 32'd0) ? PH_SKIP : PH_TAG;
              end
              default: begin
                samples_rem_next = word_next[31:1];
                phase_next       = PH_DATA;
                if (!ok_pass && !ok_dup) begin
                  push             = 1'b1;
                  entry.kind       = KIND_ERROR;
                  entry.error_code = ERR_LAYOUT;
                  finished_next    = 1'b1;
                  layout_err       = 1'b1;
                end else begin
                  dup_mode_next = ok_dup;
                  if (word_next[31:1] == 31'd0) finished_next = 1'b1;
                end
              end
            endcase
          end
        end
        PH_FMT_BODY: begin
          if (field_idx < 5'd16) begin
            if (field_idx == 5'd2) channel_count_next[7:0] = file_byte;
            if (field_idx == 5'd3) channel_count_next[15:8] = file_byte;
            field_idx_next = field_idx + 5'd1;
          end
          if (chunk_rem != 32'd0) chunk_rem_next = chunk_rem - 32'd1;
          // fields done and declared size used up: back to tags
          if (field_idx_next >= 5'd16 && chunk_rem_next == 32'd0) begin
            phase_next     = PH_TAG;
            field_idx_next = 5'd0;
          end
        end
        PH_SKIP: begin
          if (chunk_rem != 32'd0) chunk_rem_next = chunk_rem - 32'd1;
          if (chunk_rem_next == 32'd0) begin
            phase_next     = PH_TAG;
            field_idx_next = 5'd0;
          end
        end
        PH_DATA: begin
          if (!field_idx[0]) begin
            low_hold_next  = file_byte;
            field_idx_next = field_idx | 5'd1;
          end else begin
            if (samples_rem != 31'd0) samples_rem_next = samples_rem - 31'd1;
            is_last      = (samples_rem_next == 31'd0);
            push         = 1'b1;
            entry.kind   = KIND_SAMPLE;
            entry.sample = {file_byte, low_hold};
            entry.last   = is_last;
            entry.dup    = dup_mode;
            if (dup_mode) begin
              field_idx_next = 5'd0;
            end else if (channel_count == 16'd2) begin
              entry.channel  = ch;
              field_idx_next = {3'd0, ~ch, 1'b0};
            end else begin
              field_idx_next = 5'd0;
            end
            if (is_last) finished_next = 1'b1;
          end
        end
        default: begin
          phase_next     = PH_TAG;
          field_idx_next = 5'd0;
        end
      endcase
    end

    // early end replaces whatever this byte produced
    if (end_of_file && !finished_next && !layout_err) begin
      push             = 1'b1;
      entry            = '0;
      entry.kind       = KIND_ERROR;
      entry.error_code = ERR_EOF;
      finished_next    = 1'b1;
    end
  end

  assign push_out.push  = accept && push;
  assign push_out.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      field_idx     <= 5'd0;
      word          <= 32'd0;
      chunk_rem     <= 32'd0;
      channel_count <= 16'd0;
      samples_rem   <= 31'd0;
      low_hold      <= 8'd0;
      dup_mode      <= 1'b0;
      finished      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      field_idx     <= field_idx_next;
      word          <= word_next;
      chunk_rem     <= chunk_rem_next;
      channel_count <= channel_count_next;
      samples_rem   <= samples_rem_next;
      low_hold      <= low_hold_next;
      dup_mode      <= dup_mode_next;
      finished      <= finished_next;
    end
  end

endmodule

[design/wcp_queue.sv]
// Small FIFO of parsed entries between the parser and the result stage.
module wcp_queue
  import wcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  wcp_push_t  push_in,
  output logic       full,
  output logic       head_valid,
  output wcp_entry_t head,
  input  logic       pop
);

  wcp_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_in.push) slots[wr_ptr] <= push_in.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_in.push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W + 1)'(push_in.push) - (QPTR_W + 1)'(do_pop);
    end
  end

endmodule

[design/wcp_back.sv]
// Result stage: expands queue entries into result transfers through an output register.
module wcp_back
  import wcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  wcp_entry_t head,
  output logic       pop,
  wcp_out_if.source  result_out
);

  logic second;
  logic load;
  logic first_of_dup;

  assign load         = head_valid && (!result_out.valid || result_out.ready);
  assign first_of_dup = head.dup && !second;
  assign pop          = load && !first_of_dup;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
      second           <= 1'b0;
    end else begin
      if (load) begin
        result_out.valid <= 1'b1;
        second           <= first_of_dup;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out.kind       <= head.kind;
      result_out.sample     <= head.sample;
      result_out.error_code <= head.error_code;
      // duplicated mono: left copy first, last flag only on the right copy
      if (head.dup) begin
        result_out.channel <= second;
        result_out.last    <= second && head.last;
      end else begin
        result_out.channel <= head.channel;
        result_out.last    <= head.last;
      end
    end
  end

endmodule

[design/wav_chunk_parser_pcm16.sv]
// Top level of the WAV chunk parser with signed 16-bit PCM output.
// The block takes one file byte per cycle and never iterates: the parser in
// front updates its phase, byte index and counters as each byte is accepted, so
// input ready stays high as long as the four-entry result queue has room.
// Each byte leaves at most one queue entry; the result stage behind drains
// one result per cycle into a registered output while that output is taken,
// and a duplicated mono sample yields two output transfers, which its two file
// bytes cover. Throughput is thus one byte per cycle when results are taken at
// once; results pass from the queue through the output register. The
// stereo_output register (byte address 0) is read when the data byte count
// completes and should be written while the block is idle.
module wav_chunk_parser_pcm16
  import wcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wcp_in_if.sink      byte_in,
  wcp_out_if.source   result_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       stereo_output;
  logic       accept;
  logic       full;
  logic       head_valid;
  logic       pop;
  wcp_entry_t head;
  wcp_push_t  push;

  assign pready        = 1'b1;
  assign byte_in.ready = !full;
  assign accept        = byte_in.valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_output <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 ({paddr[2], 2'b00} == REG_STEREO_OUTPUT)) begin
      stereo_output <= pwdata[0];
    end
  end

  assign prdata = ({paddr[2], 2'b00} == REG_STEREO_OUTPUT) ? {31'd0, stereo_output} : 32'd0;

  wcp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .file_byte     (byte_in.file_byte),
    .end_of_file   (byte_in.end_of_file),
    .stereo_output (stereo_output),
    .push_out      (push)
  );

  wcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_in    (push),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  wcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

[tb/sv/wav_chunk_parser_pcm16_tb.sv]
// Testbench for wav_chunk_parser_pcm16: one randomized WAV file checked against a byte-level parser.
`timescale 1ns / 100ps

module wav_chunk_parser_pcm16_tb
  import wcp_pkg::*;
();

  localparam int RUN_LIMIT_NS  = 5_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 40;
  // no register at this index: writes there must change nothing
  localparam logic [2:0] REG_SPARE = 3'd1;

  typedef enum logic [3:0] {
    ST_TAG, ST_RIFF_SIZE, ST_FMT_SIZE, ST_FMT_BODY,
    ST_SKIP_SIZE, ST_SKIP, ST_DATA_SIZE, ST_DATA
  } parse_phase_t;

  typedef enum {PACE_FLAT, PACE_LIGHT, PACE_HEAVY} pace_t;

  typedef enum {
    END_CLEAN, END_EOF_DATA, END_EOF_HEAD, END_BAD_LAYOUT, END_EMPTY_DATA
  } file_end_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               channel;
    logic               last;
    logic               error_code;
  } pcm_result_t;

  class wav_parse_board_t;
    parse_phase_t phase;
    logic [4:0]   fidx;
    logic [31:0]  word;
    logic [31:0]  chunk_left;
    logic [15:0]  chans;
    logic [15:0]  fmt_tag;
    logic [30:0]  samples_left;
    logic [7:0]   low_hold;
    logic         dup;
    logic         done;
    logic         stereo;
    pcm_result_t  results_due[$];
    int           faults;

    function new();
      phase        = ST_TAG;
      fidx         = '0;
      word         = '0;
      chunk_left   = '0;
      chans        = '0;
      fmt_tag      = '0;
      samples_left = '0;
      low_hold     = '0;
      dup          = 1'b0;
      done         = 1'b0;
      stereo       = 1'b0;
      faults       = 0;
    endfunction

    task report(string what);
      faults++;
      if (faults <= PRINT_LIMIT) $display("mismatch %0d at %0t: %s", faults, $realtime, what);
    endtask

    function void enter(parse_phase_t p);
      phase = p;
      fidx  = '0;
    endfunction

    function pcm_result_t pcm_out(logic kind, logic [15:0] smp, logic ch, logic last,
                                  logic code);
      pcm_result_t r;
      r.kind       = kind;
      r.sample     = smp;
      r.channel    = ch;
      r.last       = last;
      r.error_code = code;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      pcm_result_t now_out[$];
      logic [1:0]  idx;
      logic        bad_layout;
      logic        pass_ok;
      logic        dup_ok;
      logic        ch;
      logic        fin;
      bad_layout = 1'b0;
      if (done) return;
      case (phase)
        ST_TAG, ST_RIFF_SIZE, ST_FMT_SIZE, ST_SKIP_SIZE, ST_DATA_SIZE: begin
          idx  = fidx[1:0];
          word = ((idx == 2'd0) ? 32'd0 : word) | (32'(b) << (8 * idx));
          fidx = 5'(idx) + 5'd1;
          if (fidx == 5'd4) begin
            case (phase)
              ST_TAG: begin
                if (word == TAG_RIFF) enter(ST_RIFF_SIZE);
                else if (word == TAG_WAVE) enter(ST_TAG);
                else if (word == TAG_FMT) enter(ST_FMT_SIZE);
                else if (word == TAG_DATA) enter(ST_DATA_SIZE);
                else enter(ST_SKIP_SIZE);
              end
              ST_RIFF_SIZE: enter(ST_TAG);
              ST_FMT_SIZE: begin
                chunk_left = word;
                enter(ST_FMT_BODY);
              end
              ST_SKIP_SIZE: begin
                chunk_left = word;
                if (word != 32'd0) enter(ST_SKIP);
                else enter(ST_TAG);
              end
              default: begin
                // data byte count done: settle the channel layout now
                pass_ok      = (stereo && chans == 16'd2) || (!stereo && chans == 16'd1);
                dup_ok       = stereo && chans == 16'd1;
                samples_left = word[31:1];
                enter(ST_DATA);
                if (!pass_ok && !dup_ok) begin
                  now_out.push_back(pcm_out(KIND_ERROR, 16'd0, 1'b0, 1'b0, ERR_LAYOUT));
                  done       = 1'b1;
                  bad_layout = 1'b1;
                end else begin
                  dup = dup_ok;
                  if (samples_left == 31'd0) done = 1'b1;
                end
              end
            endcase
          end
        end
        ST_FMT_BODY: begin
          if (fidx < 5'd16) begin
            case (fidx)
              5'd0: fmt_tag = {8'd0, b};
              5'd1: fmt_tag[15:8] = b;
              5'd2: chans = {8'd0, b};
              5'd3: chans[15:8] = b;
              default: ;
            endcase
            fidx = fidx + 5'd1;
          end
          if (chunk_left != 32'd0) chunk_left = chunk_left - 32'd1;
          if (fidx >= 5'd16 && chunk_left == 32'd0) enter(ST_TAG);
        end
        ST_SKIP: begin
          if (chunk_left != 32'd0) chunk_left = chunk_left - 32'd1;
          if (chunk_left == 32'd0) enter(ST_TAG);
        end
        default: begin
          if (!fidx[0]) begin
            low_hold = b;
            fidx[0]  = 1'b1;
          end else begin
            ch = fidx[1];
            if (samples_left != 31'd0) samples_left = samples_left - 31'd1;
            fin = (samples_left == 31'd0);
            if (dup) begin
              now_out.push_back(pcm_out(KIND_SAMPLE, {b, low_hold}, 1'b0, 1'b0, 1'b0));
              now_out.push_back(pcm_out(KIND_SAMPLE, {b, low_hold}, 1'b1, fin, 1'b0));
              fidx = '0;
            end else if (chans == 16'd2) begin
              now_out.push_back(pcm_out(KIND_SAMPLE, {b, low_hold}, ch, fin, 1'b0));
              fidx = {3'd0, ~ch, 1'b0};
            end else begin
              now_out.push_back(pcm_out(KIND_SAMPLE, {b, low_hold}, 1'b0, fin, 1'b0));
              fidx = '0;
            end
            if (fin) done = 1'b1;
          end
        end
      endcase
      // early end replaces whatever this byte produced
      if (eof && !done && !bad_layout) begin
        now_out.delete();
        now_out.push_back(pcm_out(KIND_ERROR, 16'd0, 1'b0, 1'b0, ERR_EOF));
        done = 1'b1;
      end
      foreach (now_out[i]) results_due.push_back(now_out[i]);
    endfunction

    task check_result(pcm_result_t got);
      pcm_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0b sample %0d code %0b",
                         got.kind, got.sample, got.error_code));
        return;
      end
      want = results_due.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0b, want %0b", got.kind, want.kind));
      if (got.sample !== want.sample)
        report($sformatf("sample %0d, want %0d", got.sample, want.sample));
      if (got.channel !== want.channel)
        report($sformatf("channel %0b, want %0b", got.channel, want.channel));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0b, want %0b", got.error_code, want.error_code));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wcp_in_if  byte_if();
  wcp_out_if res_if();

  wav_parse_board_t board;
  logic [7:0]       wav_bytes[$];
  pace_t            in_pace  = PACE_FLAT;
  pace_t            out_pace = PACE_FLAT;
  int               in_left  = 0;
  int               out_left = 0;

  wav_chunk_parser_pcm16 u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_if),
    .result_out (res_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk = ~clk;

  // Switch pace every 8 to 48 transfers so flat stretches alternate with light and heavy idling.
  function automatic int draw_gap(inout pace_t pace, inout int left);
    if (left <= 0) begin
      pace = pace_t'($urandom_range(0, 2));
      left = $urandom_range(8, 48);
    end
    left--;
    case (pace)
      PACE_FLAT:  return 0;
      PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
      default:    return int'($urandom_range(0, 16));
    endcase
  endfunction

  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_noise(int n);
    for (int i = 0; i < n; i++) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] odd_tag();
    logic [31:0] t;
    t = $urandom;
    if (t inside {TAG_RIFF, TAG_WAVE, TAG_FMT, TAG_DATA}) t[0] = ~t[0];
    return t;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = draw_gap(in_pace, in_left);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid       <= 1'b1;
    byte_if.file_byte   <= b;
    byte_if.end_of_file <= eof;
    do @(posedge clk); while (byte_if.ready !== 1'b1);
    board.note_byte(b, eof);
  endtask

  // Write only with nothing in flight, after letting the result path settle.
  task automatic set_register(input logic [2:0] idx, input logic v);
    byte_if.valid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= {31'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_STEREO_OUTPUT) board.stereo = v;
  endtask

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_sink
    int          stall;
    pcm_result_t got;
    forever begin
      stall = draw_gap(out_pace, out_left);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      got = '{res_if.kind, res_if.sample, res_if.channel, res_if.last, res_if.error_code};
      board.check_result(got);
    end
  end

  initial begin : stimulus
    file_end_t   ending;
    logic        stereo_final;
    logic        with_fmt;
    logic [15:0] chans;
    logic [31:0] fmt_size;
    logic [31:0] data_count;
    int          n_data;
    int          pick;
    int          mid_mark;
    int          cfg_mark;
    int          data_start;
    int          eof_at;
    board = new();
    rst                 <= 1'b1;
    byte_if.valid       <= 1'b0;
    byte_if.file_byte   <= 8'd0;
    byte_if.end_of_file <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= 3'd0;
    pwdata              <= 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_register(REG_STEREO_OUTPUT, 1'b1);
    set_register(REG_SPARE, 1'b1);

    // The parser stops for good after one file, so each run picks how its file ends.
    pick = $urandom_range(0, 19);
    if (pick < 12) ending = END_CLEAN;
    else if (pick < 15) ending = END_EOF_DATA;
    else if (pick < 17) ending = END_BAD_LAYOUT;
    else if (pick < 19) ending = END_EOF_HEAD;
    else ending = END_EMPTY_DATA;

    with_fmt = 1'b1;
    if (ending == END_BAD_LAYOUT) begin
      stereo_final = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: begin
          stereo_final = 1'b0;
          chans        = 16'd2;
        end
        1: begin
          with_fmt = 1'b0;
          chans    = 16'd0;
        end
        2: chans = 16'h0101;
        default: chans = 16'($urandom_range(3, 65535));
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          stereo_final = 1'b1;
          chans        = 16'd2;
        end
        1: begin
          stereo_final = 1'b0;
          chans        = 16'd1;
        end
        default: begin
          stereo_final = 1'b1;
          chans        = 16'd1;
        end
      endcase
    end
    n_data = $urandom_range(760, 900);

    wav_bytes.delete();
    put_word(TAG_RIFF);
    put_word(($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'($urandom));
    put_word(TAG_WAVE);
    put_word(odd_tag());
    put_word(32'd0);
    mid_mark = wav_bytes.size();
    put_word({8'h58, TAG_RIFF[23:0]});
    pick = $urandom_range(1, 24);
    put_word(pick);
    put_noise(pick);
    if (with_fmt) begin
      case ($urandom_range(0, 3))
        0: fmt_size = 32'd0;
        1: fmt_size = 32'd14;
        2: fmt_size = 32'd16;
        default: fmt_size = $urandom_range(17, 40);
      endcase
      put_word(TAG_FMT);
      put_word(fmt_size);
      put_word({chans, 16'($urandom)});
      put_noise(((fmt_size > 32'd16) ? int'(fmt_size) : 16) - 4);
    end
    if ($urandom_range(0, 1) != 0) begin
      pick = $urandom_range(0, 8);
      put_word(odd_tag());
      put_word(pick);
      put_noise(pick);
    end
    cfg_mark = wav_bytes.size();
    case (ending)
      END_EMPTY_DATA: data_count = $urandom_range(0, 1);
      END_EOF_DATA:   data_count = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : n_data;
      default:        data_count = n_data;
    endcase
    put_word(TAG_DATA);
    put_word(data_count);
    data_start = wav_bytes.size();
    // full-scale negative and positive, then zero and minus one
    put_word(32'h7FFF_8000);
    put_word(32'hFFFF_0000);
    put_noise(n_data - 8);

    eof_at = wav_bytes.size() - 1;
    if (ending == END_EOF_DATA)
      eof_at = data_start + $urandom_range(n_data / 2, 2 * (n_data / 2) - 2);
    if (ending == END_EOF_HEAD) eof_at = $urandom_range(0, data_start - 1);

    for (int i = 0; i < wav_bytes.size(); i++) begin
      if (i == mid_mark) set_register(REG_STEREO_OUTPUT, 1'b0);
      if (i == cfg_mark) set_register(REG_STEREO_OUTPUT, stereo_final);
      send_byte(wav_bytes[i], i == eof_at);
      if (i == eof_at) break;
    end
    // parser is finished: trailing bytes must stay silent
    for (int k = 0; k < 12; k++) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    byte_if.valid <= 1'b0;

    for (int w = 0; w < DRAIN_LIMIT && board.results_due.size() != 0; w++) @(posedge clk);
    if (board.results_due.size() != 0)
      board.report($sformatf("%0d results never arrived", board.results_due.size()));
    repeat (SETTLE_CYCLES * 5) @(posedge clk);
    if (board.faults == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
